/* rtl/ctaphid_pkg.sv */
// Shared types and constants of the CTAPHID message reassembler.
package ctaphid_pkg;

    // Report framing
    localparam int REPORT_BYTES = 64;
    localparam int POS_W        = $clog2(REPORT_BYTES);
    localparam int INIT_DATA    = 57;
    localparam int CONT_DATA    = 59;

    // Channel and command codes
    localparam logic [31:0] CID_ALL    = 32'hFFFF_FFFF;
    localparam logic [6:0]  CMD_PING   = 7'h01;
    localparam logic [6:0]  CMD_MSG    = 7'h03;
    localparam logic [6:0]  CMD_INIT   = 7'h06;
    localparam logic [6:0]  CMD_WINK   = 7'h08;
    localparam logic [6:0]  CMD_CBOR   = 7'h10;
    localparam logic [6:0]  CMD_CANCEL = 7'h11;
    localparam logic [7:0]  HDR_INIT   = {1'b1, CMD_INIT};

    // Input opcodes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Result kinds
    localparam logic [2:0] RK_ERROR  = 3'd0;
    localparam logic [2:0] RK_EXEC   = 3'd1;
    localparam logic [2:0] RK_WINK   = 3'd2;
    localparam logic [2:0] RK_CANCEL = 3'd3;
    localparam logic [2:0] RK_READ   = 3'd4;

    // Error kinds
    localparam logic [2:0] ERR_CID     = 3'd0;
    localparam logic [2:0] ERR_BUSY    = 3'd1;
    localparam logic [2:0] ERR_SEQ     = 3'd2;
    localparam logic [2:0] ERR_LEN     = 3'd3;
    localparam logic [2:0] ERR_CMD     = 3'd4;
    localparam logic [2:0] ERR_TIMEOUT = 3'd5;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

    // Output queue
    localparam int OUT_FIFO_DEPTH = 4;
    localparam int OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] channel_id;
        logic [6:0]  command_code;
        logic [2:0]  error_kind;
        logic [11:0] message_length;
        logic        do_wink;
        logic [7:0]  read_data;
    } t_result;

endpackage

/* rtl/ctaphid_out_fifo.sv */
// Small result queue between the reassembler core and the output channel.
module ctaphid_out_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  ctaphid_pkg::t_result             i_push_data,
    input  logic                             i_pop,
    output logic                             o_valid,
    output ctaphid_pkg::t_result             o_data,
    output logic [ctaphid_pkg::OUT_CNT_W-1:0] o_count
);
    import ctaphid_pkg::*;

    localparam int PW = $clog2(OUT_FIFO_DEPTH);

    t_result              r_mem [OUT_FIFO_DEPTH];
    logic [PW-1:0]        r_wr_ptr;
    logic [PW-1:0]        r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + OUT_CNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - OUT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/ctaphid_message_reassembler.sv */
// Top level of the CTAPHID single-channel message reassembler.
// One item is taken per clock while o_stall is low: a report byte, a time tick or a
// buffer read. Each item is handled in a single pass, so items may arrive back to back
// with no gap; a result, when an item causes one, is registered in the result stage,
// with the buffer read data registered beside it, and then waits in a four-entry queue.
// o_stall is high while the queue and result stage together hold three or more results.
// The message buffer is a single-port-write, single-port-read memory of BUFFER_BYTES
// bytes with no clearing pass after reset; a read of a byte never written returns
// undefined data. timeout_ticks is written through i_cfg_wr_en / i_cfg_wr_data and
// should only be changed while no transfer is in flight.
module ctaphid_message_reassembler #(
    parameter int BUFFER_BYTES = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_report_byte,
    input  logic        i_wait_for_user,
    input  logic [10:0] i_read_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_channel_id,
    output logic [6:0]  o_command_code,
    output logic [2:0]  o_error_kind,
    output logic [11:0] o_message_length,
    output logic        o_do_wink,
    output logic [7:0]  o_read_data
);
    import ctaphid_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int RW = (AW > 11) ? AW : 11;
    localparam logic [15:0] LEN_MAX = 16'(BUFFER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPORT_BYTES - 1);

    typedef enum logic [2:0] {
        V_ACCEPT,
        V_CID,
        V_BUSY,
        V_SEQ,
        V_LEN,
        V_DROP
    } t_verdict;

    // Protocol state
    logic [15:0]      r_timeout_ticks;
    logic             r_busy,            n_busy;
    logic [31:0]      r_active_cid,      n_active_cid;
    logic [6:0]       r_active_command,  n_active_command;
    logic [6:0]       r_expected_seq,    n_expected_seq;
    logic [CW-1:0]    r_total_count,     n_total_count;
    logic [CW-1:0]    r_received_count,  n_received_count;
    logic [31:0]      r_tick_now,        n_tick_now;
    logic [31:0]      r_expire_tick,     n_expire_tick;
    logic [POS_W-1:0] r_byte_position,   n_byte_position;
    logic [31:0]      r_header_cid,      n_header_cid;
    logic [7:0]       r_header_type_cmd, n_header_type_cmd;
    logic [7:0]       r_header_count_high, n_header_count_high;
    t_verdict         r_frame_verdict,   n_frame_verdict;

    // Result stage
    logic             r_p_valid;
    t_result          r_p;
    logic             r_rd_ok;
    logic [7:0]       r_rd_data;

    // Message buffer
    logic [7:0]       r_buf [BUFFER_BYTES];

    logic             w_accept;
    logic             w_res_valid;
    t_result          w_res;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic             w_rd_en;
    logic             w_rd_in_range;
    logic [RW-1:0]    w_ridx_ext;
    logic [AW-1:0]    w_raddr;
    t_result          w_push_data;
    logic             w_fifo_valid;
    t_result          w_fifo_data;
    logic [OUT_CNT_W-1:0] w_fifo_count;

    // Helper terms of the byte path
    logic             w_is_init;
    logic [15:0]      w_len;
    logic [POS_W-1:0] w_init_idx;
    logic [CW-1:0]    w_init_lim;
    logic [POS_W-1:0] w_cont_off;
    logic [CW-1:0]    w_left;
    logic [CW-1:0]    w_cont_n;
    logic [CW-1:0]    w_cont_idx;
    logic             w_complete;
    logic [6:0]       w_cmd;

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = ({1'b0, w_fifo_count} + (OUT_CNT_W + 1)'(r_p_valid))
                      >= (OUT_CNT_W + 1)'(OUT_FIFO_DEPTH - 1);

    assign w_ridx_ext    = RW'(i_read_index);
    assign w_raddr       = w_ridx_ext[AW-1:0];
    assign w_rd_in_range = {21'd0, i_read_index} < 32'(BUFFER_BYTES);
    assign w_rd_en       = w_accept && (i_opcode == OP_READ);

    assign w_is_init  = r_header_type_cmd[7];
    assign w_len      = {r_header_count_high, i_report_byte};
    assign w_init_idx = r_byte_position - POS_W'(7);
    assign w_init_lim = (r_total_count < CW'(INIT_DATA)) ? r_total_count : CW'(INIT_DATA);
    assign w_cont_off = r_byte_position - POS_W'(5);
    assign w_left     = (r_total_count > r_received_count) ?
                        (r_total_count - r_received_count) : '0;
    assign w_cont_n   = (w_left < CW'(CONT_DATA)) ? w_left : CW'(CONT_DATA);
    assign w_cont_idx = r_received_count + CW'(w_cont_off);

    always_comb begin
        n_busy              = r_busy;
        n_active_cid        = r_active_cid;
        n_active_command    = r_active_command;
        n_expected_seq      = r_expected_seq;
        n_total_count       = r_total_count;
        n_received_count    = r_received_count;
        n_tick_now          = r_tick_now;
        n_expire_tick       = r_expire_tick;
        n_byte_position     = r_byte_position;
        n_header_cid        = r_header_cid;
        n_header_type_cmd   = r_header_type_cmd;
        n_header_count_high = r_header_count_high;
        n_frame_verdict     = r_frame_verdict;
        w_res_valid         = 1'b0;
        w_res               = '0;
        w_we                = 1'b0;
        w_waddr             = '0;
        w_complete          = 1'b0;
        w_cmd               = r_active_command;

        if (w_accept) begin
            case (i_opcode)
                OP_TICK: begin
                    n_tick_now = r_tick_now + 32'd1;
                    if (r_busy && (n_tick_now > r_expire_tick)) begin
                        n_busy             = 1'b0;
                        w_res_valid        = 1'b1;
                        w_res.result_kind  = RK_ERROR;
                        w_res.channel_id   = r_active_cid;
                        w_res.error_kind   = ERR_TIMEOUT;
                    end
                end
                OP_READ: begin
                    w_res_valid       = 1'b1;
                    w_res.result_kind = RK_READ;
                end
                OP_BYTE: begin
                    if (r_byte_position < POS_W'(4)) begin
                        case (r_byte_position[1:0])
                            2'd0:    n_header_cid = {24'd0, i_report_byte};
                            2'd1:    n_header_cid[15:8] = i_report_byte;
                            2'd2:    n_header_cid[23:16] = i_report_byte;
                            default: n_header_cid[31:24] = i_report_byte;
                        endcase
                    end else if (r_byte_position == POS_W'(4)) begin
                        n_header_type_cmd = i_report_byte;
                        if ((r_header_cid == '0) ||
                            ((r_header_cid == CID_ALL) && (i_report_byte != HDR_INIT))) begin
                            n_frame_verdict = V_CID;
                        end else if (r_busy && (r_header_cid != r_active_cid)) begin
                            n_frame_verdict = V_BUSY;
                        end else if (i_report_byte[7]) begin
                            n_frame_verdict = V_ACCEPT;
                        end else if (!r_busy) begin
                            n_frame_verdict = V_DROP;
                        end else if (i_report_byte[6:0] != r_expected_seq) begin
                            n_frame_verdict = V_SEQ;
                        end else begin
                            n_frame_verdict = V_ACCEPT;
                        end
                    end else begin
                        if (r_byte_position == POS_W'(5)) begin
                            n_header_count_high = i_report_byte;
                        end
                        if (w_is_init && (r_frame_verdict == V_ACCEPT)) begin
                            if (r_byte_position == POS_W'(6)) begin
                                // An init other than INIT aborts a running transaction
                                // unless the host is waiting for the user.
                                if (!i_wait_for_user && r_busy &&
                                    (r_header_type_cmd != HDR_INIT)) begin
                                    n_frame_verdict = V_SEQ;
                                end else if (w_len > LEN_MAX) begin
                                    n_frame_verdict = V_LEN;
                                end else begin
                                    n_total_count = CW'(w_len);
                                end
                            end else if (r_byte_position >= POS_W'(7)) begin
                                if (CW'(w_init_idx) < w_init_lim) begin
                                    w_we    = 1'b1;
                                    w_waddr = AW'(w_init_idx);
                                end
                            end
                        end else if (!w_is_init && (r_frame_verdict == V_ACCEPT) &&
                                     r_busy) begin
                            if ((r_received_count < r_total_count) &&
                                (CW'(w_cont_off) < (r_total_count - r_received_count))) begin
                                w_we    = 1'b1;
                                w_waddr = w_cont_idx[AW-1:0];
                            end
                        end
                    end

                    if (r_byte_position == POS_LAST) begin
                        n_byte_position = '0;
                        case (r_frame_verdict)
                            V_CID: begin
                                w_res_valid      = 1'b1;
                                w_res.channel_id = r_header_cid;
                                w_res.error_kind = ERR_CID;
                            end
                            V_BUSY: begin
                                w_res_valid      = 1'b1;
                                w_res.channel_id = r_header_cid;
                                w_res.error_kind = ERR_BUSY;
                            end
                            V_SEQ: begin
                                n_active_cid     = r_header_cid;
                                n_busy           = 1'b0;
                                w_res_valid      = 1'b1;
                                w_res.channel_id = r_header_cid;
                                w_res.error_kind = ERR_SEQ;
                            end
                            V_LEN: begin
                                n_active_cid     = r_header_cid;
                                w_res_valid      = 1'b1;
                                w_res.channel_id = r_header_cid;
                                w_res.error_kind = ERR_LEN;
                            end
                            V_DROP: begin
                                n_active_cid = r_header_cid;
                            end
                            V_ACCEPT: begin
                                if (w_is_init) begin
                                    n_active_cid     = r_header_cid;
                                    n_received_count = w_init_lim;
                                    n_busy           = 1'b1;
                                    n_active_command = r_header_type_cmd[6:0];
                                    n_expected_seq   = '0;
                                    n_expire_tick    = r_tick_now + {16'd0, r_timeout_ticks};
                                    w_cmd            = r_header_type_cmd[6:0];
                                    w_complete       = (w_init_lim == r_total_count);
                                end else if (r_busy) begin
                                    n_active_cid     = r_header_cid;
                                    n_received_count = r_received_count + w_cont_n;
                                    n_expected_seq   = r_expected_seq + 7'd1;
                                    w_complete       = (n_received_count == r_total_count);
                                end
                            end
                            default: ;
                        endcase

                        if (w_complete) begin
                            n_expire_tick        = '1;
                            n_busy               = 1'b0;
                            w_res_valid          = 1'b1;
                            w_res.channel_id     = r_header_cid;
                            w_res.command_code   = w_cmd;
                            w_res.message_length = 12'(r_total_count);
                            w_res.result_kind    = RK_EXEC;
                            case (w_cmd)
                                CMD_MSG, CMD_CBOR, CMD_INIT, CMD_PING: begin
                                    if (i_wait_for_user) begin
                                        w_res.error_kind = ERR_BUSY;
                                    end else if (((w_cmd == CMD_MSG) &&
                                                  (r_total_count < CW'(4))) ||
                                                 ((w_cmd == CMD_CBOR) &&
                                                  (r_total_count == '0))) begin
                                        w_res.error_kind = ERR_LEN;
                                    end else begin
                                        w_res.error_kind = ERR_CID;
                                    end
                                    // Any error above turns the result into an error
                                    // response that carries only channel and error.
                                    if (i_wait_for_user || (w_res.error_kind == ERR_LEN))
                                    begin
                                        w_res.result_kind    = RK_ERROR;
                                        w_res.command_code   = '0;
                                        w_res.message_length = '0;
                                    end else begin
                                        w_res.error_kind = '0;
                                    end
                                end
                                CMD_WINK: begin
                                    w_res.result_kind = RK_WINK;
                                    w_res.do_wink     = !i_wait_for_user;
                                end
                                CMD_CANCEL: begin
                                    w_res.result_kind = RK_CANCEL;
                                end
                                default: begin
                                    w_res.result_kind    = RK_ERROR;
                                    w_res.command_code   = '0;
                                    w_res.message_length = '0;
                                    w_res.error_kind     = ERR_CMD;
                                end
                            endcase
                        end
                    end else begin
                        n_byte_position = r_byte_position + POS_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks     <= TIMEOUT_RESET;
            r_busy              <= 1'b0;
            r_active_cid        <= '0;
            r_active_command    <= '0;
            r_expected_seq      <= '0;
            r_total_count       <= '0;
            r_received_count    <= '0;
            r_tick_now          <= '0;
            r_expire_tick       <= '1;
            r_byte_position     <= '0;
            r_header_cid        <= '0;
            r_header_type_cmd   <= '0;
            r_header_count_high <= '0;
            r_frame_verdict     <= V_ACCEPT;
            r_p_valid           <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout_ticks <= i_cfg_wr_data;
            end
            r_busy              <= n_busy;
            r_active_cid        <= n_active_cid;
            r_active_command    <= n_active_command;
            r_expected_seq      <= n_expected_seq;
            r_total_count       <= n_total_count;
            r_received_count    <= n_received_count;
            r_tick_now          <= n_tick_now;
            r_expire_tick       <= n_expire_tick;
            r_byte_position     <= n_byte_position;
            r_header_cid        <= n_header_cid;
            r_header_type_cmd   <= n_header_type_cmd;
            r_header_count_high <= n_header_count_high;
            r_frame_verdict     <= n_frame_verdict;
            r_p_valid           <= w_accept && w_res_valid;
        end
    end

    // Result stage payload; the buffer byte is registered in the same cycle and joins it at the queue input.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p     <= w_res;
            r_rd_ok <= w_rd_en && w_rd_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[w_waddr] <= i_report_byte;
        end
        if (w_rd_en) begin
            r_rd_data <= r_buf[w_raddr];
        end
    end

    always_comb begin
        w_push_data           = r_p;
        w_push_data.read_data = r_rd_ok ? r_rd_data : '0;
    end

    ctaphid_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_p_valid),
        .i_push_data (w_push_data),
        .i_pop       (!i_stall),
        .o_valid     (w_fifo_valid),
        .o_data      (w_fifo_data),
        .o_count     (w_fifo_count)
    );

    assign o_valid          = w_fifo_valid;
    assign o_result_kind    = w_fifo_data.result_kind;
    assign o_channel_id     = w_fifo_data.channel_id;
    assign o_command_code   = w_fifo_data.command_code;
    assign o_error_kind     = w_fifo_data.error_kind;
    assign o_message_length = w_fifo_data.message_length;
    assign o_do_wink        = w_fifo_data.do_wink;
    assign o_read_data      = w_fifo_data.read_data;

endmodule

/* bench/tb_ctaphid_message_reassembler.sv */
// Self-checking testbench for the CTAPHID message reassembler.
`timescale 1ns / 100ps

module tb_ctaphid_message_reassembler;
    import ctaphid_pkg::*;

    localparam int BUF_BYTES = 2048;
    localparam int DRAIN_CYCLES = 6;
    localparam int MSG_MIN_LEN = 4;
    // The block ignores this opcode.
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [31:0] CHAN_A = 32'h1A2B_3C4D;
    localparam logic [31:0] CHAN_B = 32'hC0DE_0042;

    typedef enum logic [2:0] {
        VD_ACCEPT, VD_CID, VD_BUSY, VD_SEQ, VD_LEN, VD_DROP
    } frame_verdict_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_TICK;
    logic [7:0]  i_report_byte = '0;
    logic        i_wait_for_user = 1'b0;
    logic [10:0] i_read_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_result_kind;
    logic [31:0] o_channel_id;
    logic [6:0]  o_command_code;
    logic [2:0]  o_error_kind;
    logic [11:0] o_message_length;
    logic        o_do_wink;
    logic [7:0]  o_read_data;

    ctaphid_message_reassembler #(
        .BUFFER_BYTES(BUF_BYTES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_opcode(i_opcode),
        .i_report_byte(i_report_byte),
        .i_wait_for_user(i_wait_for_user),
        .i_read_index(i_read_index),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_result_kind(o_result_kind),
        .o_channel_id(o_channel_id),
        .o_command_code(o_command_code),
        .o_error_kind(o_error_kind),
        .o_message_length(o_message_length),
        .o_do_wink(o_do_wink),
        .o_read_data(o_read_data)
    );

    always #6 i_clk = ~i_clk;

    // Channel state mirrored from the block.
    logic [15:0]    timeout_reg = TIMEOUT_RESET;
    logic           ch_busy = 1'b0;
    logic [31:0]    ch_cid = '0;
    logic [6:0]     ch_cmd = '0;
    logic [6:0]     ch_seq = '0;
    logic [15:0]    msg_total = '0;
    logic [15:0]    msg_received = '0;
    logic [31:0]    tick_count = '0;
    logic [31:0]    deadline = '1;
    logic [5:0]     byte_pos = '0;
    logic [31:0]    hdr_cid = '0;
    logic [7:0]     hdr_type = '0;
    logic [7:0]     hdr_len_hi = '0;
    frame_verdict_t verdict = VD_ACCEPT;
    logic [7:0]     msg_buf [BUF_BYTES];
    bit             written [BUF_BYTES];
    int unsigned    written_list [$];

    t_result pending_results [$];

    int fail_count = 0;
    int items_sent = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mix_pct = 0;
    int ticks_inside = 0;
    bit valid_held = 1'b0;
    int hold_len = 0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;

    function automatic void add_error(input logic [31:0] cid, input logic [2:0] kind);
        t_result r;
        r = '0;
        r.result_kind = RK_ERROR;
        r.channel_id = cid;
        r.error_kind = kind;
        pending_results.push_back(r);
    endfunction

    function automatic void add_done(input logic [2:0] kind, input logic wink);
        t_result r;
        r = '0;
        r.result_kind = kind;
        r.channel_id = ch_cid;
        r.command_code = ch_cmd;
        r.message_length = msg_total[11:0];
        r.do_wink = wink;
        pending_results.push_back(r);
    endfunction

    function automatic void store_byte(input int idx, input logic [7:0] b);
        if (idx < BUF_BYTES) begin
            if (!written[idx]) begin
                written[idx] = 1'b1;
                written_list.push_back(idx);
            end
            msg_buf[idx] = b;
        end
    endfunction

    // Applies one accepted transfer to the mirrored channel state.
    function automatic void reassembler_step(input logic [1:0] op, input logic [7:0] b,
                                             input logic wfu, input logic [10:0] ridx);
        t_result r;
        int p;
        int lim;
        int off;
        int left;
        int take;
        logic [15:0] len;
        bit msg_done;
        p = int'(byte_pos);
        case (op)
            OP_TICK: begin
                tick_count = tick_count + 32'd1;
                if (ch_busy && tick_count > deadline) begin
                    ch_busy = 1'b0;
                    add_error(ch_cid, ERR_TIMEOUT);
                end
            end
            OP_READ: begin
                r = '0;
                r.result_kind = RK_READ;
                r.read_data = (int'(ridx) < BUF_BYTES) ? msg_buf[ridx] : 8'd0;
                pending_results.push_back(r);
            end
            OP_BYTE: begin
                if (p < 4) begin
                    if (p == 0) hdr_cid = '0;
                    hdr_cid[8*p +: 8] = b;
                end else if (p == 4) begin
                    hdr_type = b;
                    if (hdr_cid == '0 || (hdr_cid == CID_ALL && b != HDR_INIT))
                        verdict = VD_CID;
                    else if (ch_busy && hdr_cid != ch_cid)
                        verdict = VD_BUSY;
                    else if (b[7])
                        verdict = VD_ACCEPT;
                    else if (!ch_busy)
                        verdict = VD_DROP;
                    else if (b[6:0] != ch_seq)
                        verdict = VD_SEQ;
                    else
                        verdict = VD_ACCEPT;
                end else begin
                    if (p == 5) hdr_len_hi = b;
                    if (hdr_type[7] && verdict == VD_ACCEPT) begin
                        if (p == 6) begin
                            len = {hdr_len_hi, b};
                            if (!wfu && ch_busy && hdr_type != HDR_INIT)
                                verdict = VD_SEQ;
                            else if (len > BUF_BYTES)
                                verdict = VD_LEN;
                            else
                                msg_total = len;
                        end else if (p >= 7) begin
                            lim = (msg_total < INIT_DATA) ? int'(msg_total) : INIT_DATA;
                            if (p - 7 < lim) store_byte(p - 7, b);
                        end
                    end else if (!hdr_type[7] && verdict == VD_ACCEPT && ch_busy) begin
                        off = p - 5;
                        if (msg_received < msg_total
                            && off < int'(msg_total) - int'(msg_received))
                            store_byte(int'(msg_received) + off, b);
                    end
                end

                if (p == REPORT_BYTES - 1) begin
                    byte_pos = '0;
                    case (verdict)
                        VD_CID:  add_error(hdr_cid, ERR_CID);
                        VD_BUSY: add_error(hdr_cid, ERR_BUSY);
                        VD_SEQ: begin
                            ch_cid = hdr_cid;
                            ch_busy = 1'b0;
                            add_error(hdr_cid, ERR_SEQ);
                        end
                        VD_LEN: begin
                            ch_cid = hdr_cid;
                            add_error(hdr_cid, ERR_LEN);
                        end
                        VD_DROP: ch_cid = hdr_cid;
                        VD_ACCEPT: begin
                            msg_done = 1'b0;
                            if (hdr_type[7]) begin
                                ch_cid = hdr_cid;
                                msg_received = (msg_total < INIT_DATA) ? msg_total
                                                                       : 16'(INIT_DATA);
                                ch_busy = 1'b1;
                                ch_cmd = hdr_type[6:0];
                                ch_seq = '0;
                                deadline = tick_count + {16'd0, timeout_reg};
                                msg_done = (msg_received == msg_total);
                            end else if (ch_busy) begin
                                ch_cid = hdr_cid;
                                left = (msg_total > msg_received)
                                       ? int'(msg_total) - int'(msg_received) : 0;
                                take = (left < CONT_DATA) ? left : CONT_DATA;
                                msg_received = msg_received + 16'(take);
                                ch_seq = ch_seq + 7'd1;
                                msg_done = (msg_received == msg_total);
                            end
                            if (msg_done) begin
                                deadline = '1;
                                ch_busy = 1'b0;
                                case (ch_cmd)
                                    CMD_MSG:
                                        if (wfu) add_error(ch_cid, ERR_BUSY);
                                        else if (msg_total < MSG_MIN_LEN)
                                            add_error(ch_cid, ERR_LEN);
                                        else add_done(RK_EXEC, 1'b0);
                                    CMD_CBOR:
                                        if (wfu) add_error(ch_cid, ERR_BUSY);
                                        else if (msg_total == '0) add_error(ch_cid, ERR_LEN);
                                        else add_done(RK_EXEC, 1'b0);
                                    CMD_INIT, CMD_PING:
                                        if (wfu) add_error(ch_cid, ERR_BUSY);
                                        else add_done(RK_EXEC, 1'b0);
                                    CMD_WINK:   add_done(RK_WINK, !wfu);
                                    CMD_CANCEL: add_done(RK_CANCEL, 1'b0);
                                    default:    add_error(ch_cid, ERR_CMD);
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    byte_pos = byte_pos + 6'd1;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            $error("result_kind: expected none pending, got %0d", o_result_kind);
            fail_count++;
        end else begin
            want = pending_results.pop_front();
            check_field("result_kind", want.result_kind, o_result_kind);
            check_field("channel_id", want.channel_id, o_channel_id);
            check_field("command_code", want.command_code, o_command_code);
            check_field("error_kind", want.error_kind, o_error_kind);
            check_field("message_length", want.message_length, o_message_length);
            check_field("do_wink", want.do_wink, o_do_wink);
            check_field("read_data", want.read_data, o_read_data);
        end
    endfunction

    // Output side: checks every transfer and owns the stall, including long hold-offs.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_result();
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic drop_valid();
        if (valid_held) begin
            valid_held = 1'b0;
            i_valid <= 1'b0;
        end
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic wfu,
                             input logic [10:0] ridx);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            drop_valid();
            @(posedge i_clk);
        end
        valid_held = 1'b1;
        i_valid <= 1'b1;
        i_opcode <= op;
        i_report_byte <= b;
        i_wait_for_user <= wfu;
        i_read_index <= ridx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        reassembler_step(op, b, wfu, ridx);
        if (op != OP_NONE) items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom), 1'($urandom), 11'($urandom));
    endtask

    // Reads only bytes that have been written at least once.
    task automatic send_read();
        int unsigned idx;
        if (written_list.size() == 0) begin
            send_tick();
        end else begin
            idx = written_list[$urandom_range(0, written_list.size() - 1)];
            send_item(OP_READ, 8'($urandom), 1'($urandom), 11'(idx));
        end
    endtask

    task automatic send_report(input logic [31:0] cid, input logic [7:0] hdr,
                               input logic [15:0] len, input logic wfu_init,
                               input logic wfu_last);
        logic [7:0] b;
        logic w;
        for (int p = 0; p < REPORT_BYTES; p++) begin
            if (p < 4) b = cid[8*p +: 8];
            else if (p == 4) b = hdr;
            else if (p == 5 && hdr[7]) b = len[15:8];
            else if (p == 6 && hdr[7]) b = len[7:0];
            else b = 8'($urandom);
            if (p == 6) w = wfu_init;
            else if (p == REPORT_BYTES - 1) w = wfu_last;
            else w = 1'($urandom);
            if (p == 40) repeat (ticks_inside) send_tick();
            if ($urandom_range(0, 99) < mix_pct) begin
                if ($urandom_range(0, 2) == 0) send_tick();
                else send_read();
            end
            send_item(OP_BYTE, b, w, 11'($urandom));
        end
    endtask

    // Init report plus in-order continuations, cut short after report_cap reports.
    task automatic send_message(input logic [31:0] cid, input logic [6:0] cmd, input int len,
                                input logic wfu_init, input logic wfu_last,
                                input int report_cap);
        int conts;
        conts = (len > INIT_DATA) ? (len - INIT_DATA + CONT_DATA - 1) / CONT_DATA : 0;
        if (conts > report_cap - 1) conts = report_cap - 1;
        send_report(cid, {1'b1, cmd}, 16'(len), wfu_init,
                    (conts == 0) ? wfu_last : 1'($urandom));
        for (int s = 0; s < conts; s++)
            send_report(cid, {1'b0, 7'(s)}, 16'd0, 1'($urandom),
                        (s == conts - 1) ? wfu_last : 1'($urandom));
    endtask

    task automatic wait_for_idle();
        drop_valid();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [15:0] ticks);
        wait_for_idle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= ticks;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        timeout_reg = ticks;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_gap_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_command_dispatch();
        send_message(CHAN_A, CMD_PING, 0, 1'b0, 1'b0, 64);
        send_message(CHAN_A, CMD_MSG, 4, 1'b0, 1'b0, 64);
        send_message(CHAN_A, CMD_MSG, 3, 1'b0, 1'b0, 64);
        send_message(CHAN_A, CMD_MSG, 8, 1'b0, 1'b1, 64);
        send_message(CHAN_A, CMD_CBOR, 0, 1'b0, 1'b0, 64);
        send_message(CHAN_A, CMD_CBOR, INIT_DATA, 1'b0, 1'b0, 64);
        send_message(CID_ALL, CMD_INIT, 8, 1'b0, 1'b0, 64);
        send_message(CHAN_B, CMD_INIT, 8, 1'b0, 1'b1, 64);
        send_message(CHAN_B, CMD_WINK, 0, 1'b0, 1'b0, 64);
        send_message(CHAN_B, CMD_WINK, 0, 1'b0, 1'b1, 64);
        send_message(CHAN_B, CMD_CANCEL, 0, 1'b0, 1'b0, 64);
        send_message(CHAN_B, 7'h7F, 5, 1'b0, 1'b0, 64);
        send_item(OP_NONE, 8'hFF, 1'b1, 11'h7FF);
    endtask

    task automatic test_channel_checks();
        send_message(32'd0, CMD_PING, 1, 1'b0, 1'b0, 64);
        send_message(CID_ALL, CMD_PING, 1, 1'b0, 1'b0, 64);
        send_report(CID_ALL, 8'h00, 16'd0, 1'b0, 1'b0);
        // A continuation with no transaction open is dropped without a result.
        send_report(CHAN_B, 8'h00, 16'd0, 1'b0, 1'b0);
        send_message(CHAN_A, CMD_MSG, 200, 1'b0, 1'b0, 1);
        send_message(CHAN_B, CMD_PING, 1, 1'b0, 1'b0, 64);
        send_report(CHAN_B, 8'h00, 16'd0, 1'b0, 1'b0);
        send_report(CHAN_A, 8'h00, 16'd0, 1'b0, 1'b0);
        send_report(CHAN_A, 8'h05, 16'd0, 1'b0, 1'b0);
    endtask

    task automatic test_abort_and_length();
        send_message(CHAN_A, CMD_MSG, BUF_BYTES + 1, 1'b0, 1'b0, 1);
        send_message(CHAN_A, CMD_MSG, 65535, 1'b0, 1'b0, 1);
        send_message(CHAN_A, CMD_CBOR, 150, 1'b0, 1'b0, 1);
        send_message(CHAN_A, CMD_PING, 4, 1'b0, 1'b0, 64);
        send_message(CHAN_A, CMD_CBOR, 150, 1'b0, 1'b0, 1);
        send_message(CHAN_A, CMD_PING, 4, 1'b1, 1'b0, 64);
        send_message(CHAN_A, CMD_CBOR, 150, 1'b0, 1'b0, 1);
        send_message(CHAN_A, CMD_INIT, 8, 1'b0, 1'b0, 64);
        // An oversize init while the user is awaited must leave the open message intact.
        send_message(CHAN_A, CMD_CBOR, 150, 1'b0, 1'b0, 1);
        send_message(CHAN_A, CMD_MSG, 3000, 1'b1, 1'b0, 1);
        send_report(CHAN_A, 8'h00, 16'd0, 1'b0, 1'b0);
        send_report(CHAN_A, 8'h01, 16'd0, 1'b0, 1'b0);
    endtask

    task automatic test_timeout();
        send_tick();
        send_message(CHAN_A, CMD_MSG, 200, 1'b0, 1'b0, 1);
        send_tick();
        send_tick();
        send_report(CHAN_A, 8'h00, 16'd0, 1'b0, 1'b0);
        // The transaction expires while its continuation is still arriving.
        send_message(CHAN_A, CMD_MSG, 200, 1'b0, 1'b0, 1);
        ticks_inside = 2;
        send_report(CHAN_A, 8'h00, 16'd0, 1'b0, 1'b0);
        ticks_inside = 0;
        send_message(CHAN_B, CMD_PING, 10, 1'b0, 1'b0, 64);
    endtask

    task automatic test_long_message();
        send_message(CHAN_A, CMD_MSG, BUF_BYTES, 1'b0, 1'b0, 64);
        send_item(OP_READ, 8'h00, 1'b0, 11'h7FF);
        send_item(OP_READ, 8'hFF, 1'b1, 11'h000);
        send_item(OP_READ, 8'h00, 1'b0, 11'h400);
        send_item(OP_READ, 8'h00, 1'b1, 11'h3FF);
        repeat (12) send_read();
    endtask

    task automatic test_output_backpressure();
        hold_len = 300;
        hold_asked++;
        repeat (40) send_read();
        wait_for_idle();
    endtask

    task automatic random_sequence();
        int pick;
        logic [31:0] cid;
        logic [6:0] cmd;
        int len;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0:       cid = 32'd0;
            1:       cid = CID_ALL;
            2, 3:    cid = CHAN_B;
            4:       cid = $urandom;
            default: cid = CHAN_A;
        endcase
        case ($urandom_range(0, 7))
            0:       cmd = CMD_PING;
            1:       cmd = CMD_INIT;
            2:       cmd = CMD_WINK;
            3:       cmd = CMD_CBOR;
            4:       cmd = CMD_CANCEL;
            5:       cmd = 7'($urandom);
            default: cmd = CMD_MSG;
        endcase
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, INIT_DATA)
                                         : $urandom_range(INIT_DATA + 1, 180);
        if (pick < 60)
            send_message(cid, cmd, len, ($urandom_range(0, 3) == 0),
                         ($urandom_range(0, 3) == 0), 64);
        else if (pick < 72)
            send_message(cid, cmd, len, 1'($urandom), 1'($urandom), $urandom_range(1, 2));
        else if (pick < 82)
            send_report(cid, 8'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        else if (pick < 86)
            send_message(cid, cmd, $urandom_range(BUF_BYTES + 1, 65535), 1'($urandom),
                         1'b0, 1);
        else if (pick < 94)
            repeat ($urandom_range(1, 6)) send_read();
        else if (pick < 98)
            repeat ($urandom_range(1, 8)) send_tick();
        else
            send_item(OP_NONE, 8'($urandom), 1'($urandom), 11'($urandom));
    endtask

    task automatic test_random_traffic();
        int stop_at;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       set_idling(14, 80);
                1:       set_idling(80, 14);
                default: set_idling(0, 0);
            endcase
            write_timeout(16'($urandom_range(3, 40)));
            mix_pct = 6;
            stop_at = items_sent + 185;
            while (items_sent < stop_at) random_sequence();
            mix_pct = 0;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(14, 80);
        write_timeout(16'hFFFF);
        test_command_dispatch();
        test_channel_checks();
        test_abort_and_length();
        write_timeout(16'd1);
        test_timeout();
        set_idling(80, 14);
        write_timeout(TIMEOUT_RESET);
        test_long_message();
        test_output_backpressure();
        test_random_traffic();
        wait_for_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
